FILE: rtl/core/tmbw_pkg.sv
// Shared types, constants and the divider step for the band weight block.
package tmbw_pkg;

   localparam int MAX_SLOTS   = 4;
   localparam int TMBW_SLOTS  = 4;
   localparam int DIV_STAGES  = 8;
   localparam int BAND_LAT    = DIV_STAGES + 4;

   localparam logic [16:0] ONE_Q16 = 17'd65536;

   typedef struct packed {
      logic signed [15:0] height;
      logic signed [15:0] slope;
   } req_type;

   typedef struct packed {
      logic [1:0]  slot;
      logic [16:0] weight;
      logic        no_match;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic signed [18:0] v;
      logic signed [18:0] lo;
      logic signed [18:0] hi;
      logic [15:0]        edge_w;
   } band_in_type;

   typedef struct packed {
      logic lzero;
      logic lone;
      logic hzero;
      logic hone;
      logic hard;
      logic in_range;
   } band_flags_type;

   typedef struct packed {
      logic [19:0] rem;
      logic [15:0] quo;
   } div_state_type;

   typedef struct packed {
      logic [1:0] slot;
      logic       last;
   } tag_type;

   // Two quotient bits of a restoring division; the remainder stays below the divisor.
   function automatic div_state_type div_step2(div_state_type st, logic [19:0] dvsr);
      div_state_type nx;
      logic [19:0]   r2;
      nx = st;
      for (int i = 0; i < 2; i++) begin
         r2 = {nx.rem[18:0], 1'b0};
         if (r2 >= dvsr) begin
            nx.rem = r2 - dvsr;
            nx.quo = {nx.quo[14:0], 1'b1};
         end else begin
            nx.rem = r2;
            nx.quo = {nx.quo[14:0], 1'b0};
         end
      end
      return nx;
   endfunction

endpackage

FILE: rtl/core/tmbw_band.sv
// Pipelined band factor: two smoothstep edges combined into one Q1.16 factor.
module tmbw_band
   import tmbw_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   input  band_in_type in_band,
   output logic        out_valid,
   output logic [16:0] out_factor
);

   logic signed [18:0] dl;
   logic signed [18:0] dh;
   logic signed [18:0] edge_s;
   band_flags_type     flags_in;

   logic           valid_ff [DIV_STAGES+1];
   div_state_type  dl_ff    [DIV_STAGES+1];
   div_state_type  dh_ff    [DIV_STAGES+1];
   logic [15:0]    edge_ff  [DIV_STAGES+1];
   band_flags_type flags_ff [DIV_STAGES+1];

   logic           sq_valid_ff;
   logic [31:0]    sql_ff;
   logic [31:0]    sqh_ff;
   logic [15:0]    tl_ff;
   logic [15:0]    th_ff;
   band_flags_type sq_flags_ff;

   logic [17:0]    cl;
   logic [17:0]    ch;
   logic [49:0]    pl;
   logic [49:0]    ph;
   logic [16:0]    sl_in;
   logic [16:0]    sh_in;

   logic           mu_valid_ff;
   logic [16:0]    sl_ff;
   logic [16:0]    sh_ff;
   band_flags_type mu_flags_ff;

   logic [33:0]    bp;
   logic [16:0]    factor_in;
   logic           bd_valid_ff;
   logic [16:0]    factor_ff;

   always_comb begin
      edge_s            = $signed({3'b000, in_band.edge_w});
      dl                = in_band.v - in_band.lo + edge_s;
      dh                = in_band.v - in_band.hi;
      flags_in.lzero    = (dl <= 19'sd0);
      flags_in.lone     = (dl >= edge_s);
      flags_in.hzero    = (dh <= 19'sd0);
      flags_in.hone     = (dh >= edge_s);
      flags_in.hard     = (in_band.edge_w == 16'd0);
      flags_in.in_range = (in_band.v >= in_band.lo) && (in_band.v <= in_band.hi);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff[0] <= 1'b0;
      end else begin
         valid_ff[0] <= in_valid;
      end
      dl_ff[0]    <= '{rem: {4'b0000, dl[15:0]}, quo: 16'd0};
      dh_ff[0]    <= '{rem: {4'b0000, dh[15:0]}, quo: 16'd0};
      edge_ff[0]  <= in_band.edge_w;
      flags_ff[0] <= flags_in;
   end

   for (genvar k = 1; k <= DIV_STAGES; k++) begin : g_div
      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else begin
            valid_ff[k] <= valid_ff[k-1];
         end
         dl_ff[k]    <= div_step2(dl_ff[k-1], {4'b0000, edge_ff[k-1]});
         dh_ff[k]    <= div_step2(dh_ff[k-1], {4'b0000, edge_ff[k-1]});
         edge_ff[k]  <= edge_ff[k-1];
         flags_ff[k] <= flags_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_valid_ff <= 1'b0;
      end else begin
         sq_valid_ff <= valid_ff[DIV_STAGES];
      end
      tl_ff       <= dl_ff[DIV_STAGES].quo;
      th_ff       <= dh_ff[DIV_STAGES].quo;
      sql_ff      <= {16'd0, dl_ff[DIV_STAGES].quo} * {16'd0, dl_ff[DIV_STAGES].quo};
      sqh_ff      <= {16'd0, dh_ff[DIV_STAGES].quo} * {16'd0, dh_ff[DIV_STAGES].quo};
      sq_flags_ff <= flags_ff[DIV_STAGES];
   end

   // s = t*t*(3 - 2t) with the clamped ends forced to exactly zero and one.
   always_comb begin
      cl = 18'd196608 - {1'b0, tl_ff, 1'b0};
      ch = 18'd196608 - {1'b0, th_ff, 1'b0};
      pl = {18'd0, sql_ff} * {32'd0, cl};
      ph = {18'd0, sqh_ff} * {32'd0, ch};
      if (sq_flags_ff.lzero) begin
         sl_in = 17'd0;
      end else if (sq_flags_ff.lone) begin
         sl_in = ONE_Q16;
      end else begin
         sl_in = {1'b0, pl[47:32]};
      end
      if (sq_flags_ff.hzero) begin
         sh_in = 17'd0;
      end else if (sq_flags_ff.hone) begin
         sh_in = ONE_Q16;
      end else begin
         sh_in = {1'b0, ph[47:32]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mu_valid_ff <= 1'b0;
      end else begin
         mu_valid_ff <= sq_valid_ff;
      end
      sl_ff       <= sl_in;
      sh_ff       <= sh_in;
      mu_flags_ff <= sq_flags_ff;
   end

   always_comb begin
      bp = {17'd0, sl_ff} * {17'd0, ONE_Q16 - sh_ff};
      if (mu_flags_ff.hard) begin
         factor_in = mu_flags_ff.in_range ? ONE_Q16 : 17'd0;
      end else begin
         factor_in = bp[32:16];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bd_valid_ff <= 1'b0;
      end else begin
         bd_valid_ff <= mu_valid_ff;
      end
      factor_ff <= factor_in;
   end

   assign out_valid  = bd_valid_ff;
   assign out_factor = factor_ff;

endmodule

FILE: rtl/core/terrain_material_band_weights_top.sv
// Top level of the terrain material band weight block.
// A word is taken at a clock edge with start high and busy low; busy then stays
// high until the sequencer reaches the word's last slot, so a new word can be taken
// while earlier ones are still in the pipeline. Each word yields SLOTS result words
// on consecutive cycles, slot 0 first. The receiver cannot stall: every result
// is shown for one cycle under rsp_strobe. The rate is set by the single slot path,
// which runs one slot per cycle through the two band units and the weight divider.
module terrain_material_band_weights_top
   import tmbw_pkg::*;
#(
   parameter int SLOTS = TMBW_SLOTS
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  req_type     req_word,
   output logic        rsp_strobe,
   output rsp_type     rsp_word,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [47:0] csr_wdata
);

   localparam logic [1:0] LAST_SLOT = 2'(SLOTS - 1);

   logic [47:0] cfg_h_ff [MAX_SLOTS];
   logic [26:0] cfg_s_ff [MAX_SLOTS];

   logic               accept;
   logic               seq_active_ff;
   logic [1:0]         seq_slot_ff;
   logic signed [15:0] hold_height_ff;
   logic [8:0]         hold_slope_ff;
   logic [8:0]         slope_in;

   band_in_type hband;
   band_in_type sband;
   logic [47:0] hreg;
   logic [26:0] sreg;
   logic        hb_valid;
   logic        sb_valid;
   logic [16:0] hb;
   logic [16:0] sb;
   tag_type     tag_ff [BAND_LAT];

   logic        pr_valid_ff;
   logic [16:0] prod_ff;
   tag_type     pr_tag_ff;
   logic [33:0] pp;

   logic [16:0] pbuf_ff [MAX_SLOTS];
   logic [18:0] acc_ff;
   logic [18:0] sum;
   logic [16:0] bank_ff [MAX_SLOTS];
   logic [18:0] total_ff;
   logic        none_ff;
   logic        drain_active_ff;
   logic [1:0]  drain_idx_ff;

   logic        wa_valid_ff;
   logic [16:0] wa_prod_ff;
   logic [18:0] wa_total_ff;
   logic        wa_none_ff;
   tag_type     wa_tag_ff;
   logic        wa_ge;

   logic          wd_valid_ff [DIV_STAGES+1];
   div_state_type wd_ff       [DIV_STAGES+1];
   logic [18:0]   wd_total_ff [DIV_STAGES+1];
   logic          wd_q16_ff   [DIV_STAGES+1];
   logic          wd_none_ff  [DIV_STAGES+1];
   tag_type       wd_tag_ff   [DIV_STAGES+1];

   logic        rsp_valid_ff;
   rsp_type     rsp_ff;
   rsp_type     rsp_in;

   // Even register indexes hold a height band, odd ones a slope band.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_SLOTS; i++) begin
            cfg_h_ff[i] <= '0;
            cfg_s_ff[i] <= '0;
         end
      end else if (csr_we) begin
         if (!csr_index[0]) begin
            cfg_h_ff[csr_index[2:1]] <= csr_wdata;
         end else begin
            cfg_s_ff[csr_index[2:1]] <= csr_wdata[26:0];
         end
      end
   end

   assign busy   = reset || (seq_active_ff && (seq_slot_ff != LAST_SLOT));
   assign accept = start && !busy;

   always_comb begin
      if (req_word.slope[15]) begin
         slope_in = 9'd0;
      end else if (req_word.slope > 16'sd256) begin
         slope_in = 9'd256;
      end else begin
         slope_in = req_word.slope[8:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_active_ff <= 1'b0;
         seq_slot_ff   <= 2'd0;
      end else if (accept) begin
         seq_active_ff <= 1'b1;
         seq_slot_ff   <= 2'd0;
      end else if (seq_active_ff && (seq_slot_ff == LAST_SLOT)) begin
         seq_active_ff <= 1'b0;
      end else if (seq_active_ff) begin
         seq_slot_ff <= seq_slot_ff + 2'd1;
      end
      if (accept) begin
         hold_height_ff <= req_word.height;
         hold_slope_ff  <= slope_in;
      end
   end

   always_comb begin
      hreg         = cfg_h_ff[seq_slot_ff];
      sreg         = cfg_s_ff[seq_slot_ff];
      hband.v      = {{3{hold_height_ff[15]}}, hold_height_ff};
      hband.lo     = {{3{hreg[15]}}, hreg[15:0]};
      hband.hi     = {{3{hreg[31]}}, hreg[31:16]};
      hband.edge_w = hreg[47:32];
      sband.v      = {10'd0, hold_slope_ff};
      sband.lo     = {10'd0, sreg[8:0]};
      sband.hi     = {10'd0, sreg[17:9]};
      sband.edge_w = {7'd0, sreg[26:18]};
   end

   tmbw_band u_hband (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (seq_active_ff),
      .in_band    (hband),
      .out_valid  (hb_valid),
      .out_factor (hb)
   );

   tmbw_band u_sband (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (seq_active_ff),
      .in_band    (sband),
      .out_valid  (sb_valid),
      .out_factor (sb)
   );

   always_ff @(posedge clock) begin
      tag_ff[0] <= '{slot: seq_slot_ff, last: (seq_slot_ff == LAST_SLOT)};
      for (int i = 1; i < BAND_LAT; i++) begin
         tag_ff[i] <= tag_ff[i-1];
      end
   end

   assign pp = {17'd0, hb} * {17'd0, sb};

   always_ff @(posedge clock) begin
      if (reset) begin
         pr_valid_ff <= 1'b0;
      end else begin
         pr_valid_ff <= hb_valid && sb_valid;
      end
      prod_ff   <= pp[32:16];
      pr_tag_ff <= tag_ff[BAND_LAT-1];
   end

   assign sum = ((pr_tag_ff.slot == 2'd0) ? 19'd0 : acc_ff) + {2'b00, prod_ff};

   // The last product of a word moves all products into the bank that feeds the divider.
   always_ff @(posedge clock) begin
      if (reset) begin
         drain_active_ff <= 1'b0;
         drain_idx_ff    <= 2'd0;
      end else if (pr_valid_ff && pr_tag_ff.last) begin
         drain_active_ff <= 1'b1;
         drain_idx_ff    <= 2'd0;
      end else if (drain_active_ff && (drain_idx_ff == LAST_SLOT)) begin
         drain_active_ff <= 1'b0;
      end else if (drain_active_ff) begin
         drain_idx_ff <= drain_idx_ff + 2'd1;
      end
      if (pr_valid_ff) begin
         pbuf_ff[pr_tag_ff.slot] <= prod_ff;
         acc_ff                  <= sum;
         if (pr_tag_ff.last) begin
            for (int i = 0; i < MAX_SLOTS; i++) begin
               bank_ff[i] <= (2'(i) == pr_tag_ff.slot) ? prod_ff : pbuf_ff[i];
            end
            total_ff <= sum;
            none_ff  <= (sum == 19'd0);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wa_valid_ff <= 1'b0;
      end else begin
         wa_valid_ff <= drain_active_ff;
      end
      wa_prod_ff  <= bank_ff[drain_idx_ff];
      wa_total_ff <= total_ff;
      wa_none_ff  <= none_ff;
      wa_tag_ff   <= '{slot: drain_idx_ff, last: (drain_idx_ff == LAST_SLOT)};
   end

   // The integer bit comes first; the remaining sixteen bits are fraction.
   assign wa_ge = ({2'b00, wa_prod_ff} >= wa_total_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         wd_valid_ff[0] <= 1'b0;
      end else begin
         wd_valid_ff[0] <= wa_valid_ff;
      end
      wd_ff[0]       <= '{rem: {1'b0, {2'b00, wa_prod_ff} - (wa_ge ? wa_total_ff : 19'd0)},
                          quo: 16'd0};
      wd_total_ff[0] <= wa_total_ff;
      wd_q16_ff[0]   <= wa_ge;
      wd_none_ff[0]  <= wa_none_ff;
      wd_tag_ff[0]   <= wa_tag_ff;
   end

   for (genvar k = 1; k <= DIV_STAGES; k++) begin : g_wdiv
      always_ff @(posedge clock) begin
         if (reset) begin
            wd_valid_ff[k] <= 1'b0;
         end else begin
            wd_valid_ff[k] <= wd_valid_ff[k-1];
         end
         wd_ff[k]       <= div_step2(wd_ff[k-1], {1'b0, wd_total_ff[k-1]});
         wd_total_ff[k] <= wd_total_ff[k-1];
         wd_q16_ff[k]   <= wd_q16_ff[k-1];
         wd_none_ff[k]  <= wd_none_ff[k-1];
         wd_tag_ff[k]   <= wd_tag_ff[k-1];
      end
   end

   always_comb begin
      rsp_in.slot     = wd_tag_ff[DIV_STAGES].slot;
      rsp_in.last     = wd_tag_ff[DIV_STAGES].last;
      rsp_in.no_match = wd_none_ff[DIV_STAGES];
      if (wd_none_ff[DIV_STAGES]) begin
         rsp_in.weight = (wd_tag_ff[DIV_STAGES].slot == 2'd0) ? ONE_Q16 : 17'd0;
      end else begin
         rsp_in.weight = {wd_q16_ff[DIV_STAGES], wd_ff[DIV_STAGES].quo};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= wd_valid_ff[DIV_STAGES];
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_strobe = rsp_valid_ff;
   assign rsp_word   = rsp_ff;

   a_accept_starts_seq: assert property (@(posedge clock) disable iff (reset)
      accept |=> (seq_active_ff && (seq_slot_ff == 2'd0)))
      else $error("accepted word did not start the slot sequence");

   a_results_contiguous: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_word.last) |=>
         (rsp_strobe && (rsp_word.slot == $past(rsp_word.slot) + 2'd1)))
      else $error("results of one word are not on consecutive cycles");

   a_no_match_weight: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_word.no_match) |->
         (((rsp_word.slot == 2'd0) && (rsp_word.weight == ONE_Q16)) ||
          ((rsp_word.slot != 2'd0) && (rsp_word.weight == 17'd0))))
      else $error("forced slot weights wrong when nothing matched");

   a_weight_range: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_word.weight <= ONE_Q16))
      else $error("weight above one");

   a_drain_on_last: assert property (@(posedge clock) disable iff (reset)
      (pr_valid_ff && pr_tag_ff.last) |=> drain_active_ff)
      else $error("last product did not start the weight drain");

endmodule
